// ===== rtl/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants and types for the binary to decimal digit converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 6;
	localparam int CNT_W      = 5;
	// shift-add-3 passes per pipeline stage
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_STAGES = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef logic [MAX_DIGITS*DIGIT_W-1:0] bcd_t;

	// One double-dabble step: add 3 to every digit above 4, then shift in one bit.
	function automatic bcd_t dabble(input bcd_t b, input logic bit_in);
		bcd_t t;
		t = b;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (t[i*DIGIT_W +: DIGIT_W] > 4'd4)
				t[i*DIGIT_W +: DIGIT_W] = t[i*DIGIT_W +: DIGIT_W] + 4'd3;
		end
		return {t[MAX_DIGITS*DIGIT_W-2:0], bit_in};
	endfunction

endpackage

// ===== rtl/b2d_if.sv =====
// ----------------------------------------------------------------------------
// b2d_in_if / b2d_out_if
// Valid/ready channels for input values and output digit words.
// ----------------------------------------------------------------------------
interface b2d_in_if;
	logic                            valid;
	logic                            ready;
	logic [b2d_pkg::VALUE_BITS-1:0]  value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
	logic                        valid;
	logic                        ready;
	logic [b2d_pkg::CHAR_W-1:0]  digit_char;
	logic                        last_digit;
	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/b2d_pipe.sv =====
// ----------------------------------------------------------------------------
// b2d_pipe
// Double-dabble conversion pipeline, four bits per stage, stall by enable.
// ----------------------------------------------------------------------------
module b2d_pipe (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [b2d_pkg::VALUE_BITS-1:0]  in_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output b2d_pkg::bcd_t                   out_bcd
);
	localparam int N = b2d_pkg::NUM_STAGES;
	localparam int PAD = N * b2d_pkg::BITS_PER_STAGE;

	logic [N-1:0]          vld_s;
	b2d_pkg::bcd_t         bcd_s [N];
	logic [PAD-1:0]        bin_s [N];
	logic                  adv;
	b2d_pkg::bcd_t         nxt   [N];
	logic [PAD-1:0]        nbin  [N];

	// whole pipe moves together; bubbles are squeezed only at the tail
	assign adv = !vld_s[N-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_s[N-1];
	assign out_bcd = bcd_s[N-1];

	always_comb begin
		b2d_pkg::bcd_t b;
		logic [PAD-1:0] v;
		for (int s = 0; s < N; s++) begin
			if (s == 0) begin
				b = '0;
				v = PAD'(in_value);
			end else begin
				b = bcd_s[s-1];
				v = bin_s[s-1];
			end
			for (int k = 0; k < b2d_pkg::BITS_PER_STAGE; k++) begin
				b = b2d_pkg::dabble(b, v[PAD-1]);
				v = {v[PAD-2:0], 1'b0};
			end
			nxt[s] = b;
			nbin[s] = v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < N; s++) begin
				bcd_s[s] <= nxt[s];
				bin_s[s] <= nbin[s];
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bcd))
		else $error("pipe output changed while stalled");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted value lost at first stage");
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_bcd[b2d_pkg::DIGIT_W-1:0] <= 4'd9)
		else $error("non-decimal digit");
endmodule

// ===== rtl/binary_to_decimal_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_digits
// Unsigned 64-bit binary to ASCII decimal digits, most significant first.
// ----------------------------------------------------------------------------
// channel  dir  payload                   handshake
// inp      in   value[63:0]               valid/ready
// outp     out  digit_char[5:0],last_digit valid/ready
//
// Conversion runs in a 16-stage double-dabble pipeline (4 bits per stage).
// The serializer then emits one word per cycle while outp.ready is high: an item
// of n digits (1 to 20) gives n words at the output, which sets the sustained rate.
// The pipeline keeps filling while the serializer drains one number.
// Reset clears all valid bits; stalls on either side lose nothing.
module binary_to_decimal_digits (
	input  logic       clk,
	input  logic       arst_n,
	b2d_in_if.sink     inp,
	b2d_out_if.source  outp
);
	localparam int DW = b2d_pkg::DIGIT_W;
	localparam int CW = b2d_pkg::CNT_W;

	logic           p_valid, p_ready;
	b2d_pkg::bcd_t  p_bcd;
	b2d_pkg::bcd_t  sh_q;
	logic [CW-1:0]  left_q;
	logic           busy_q;
	logic [CW-1:0]  top_idx;

	b2d_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (inp.valid),
		.in_ready (inp.ready),
		.in_value (inp.value),
		.out_valid(p_valid),
		.out_ready(p_ready),
		.out_bcd  (p_bcd)
	);

	// index of highest nonzero digit (zero value gives 0)
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
			if (p_bcd[i*DW +: DW] != '0)
				top_idx = CW'(i);
		end
	end

	logic fin;
	assign fin = busy_q && outp.ready && left_q == '0;
	assign p_ready = !busy_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (p_valid && p_ready) begin
			busy_q <= 1'b1;
			left_q <= top_idx;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && outp.ready) begin
			left_q <= left_q - 1'b1;
		end
	end

	// MS digit aligned to the top of sh_q
	always_ff @(posedge clk) begin
		if (p_valid && p_ready) begin
			sh_q <= p_bcd << (DW * (b2d_pkg::MAX_DIGITS - 1 - int'(top_idx)));
		end else if (busy_q && outp.ready) begin
			sh_q <= sh_q << DW;
		end
	end

	assign outp.valid = busy_q;
	assign outp.digit_char = b2d_pkg::ASCII_ZERO +
		b2d_pkg::CHAR_W'(sh_q[b2d_pkg::MAX_DIGITS*DW-1 -: DW]);
	assign outp.last_digit = left_q == '0;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && outp.ready && left_q != '0 |=> busy_q && left_q == $past(left_q) - 1'b1)
		else $error("digit count skipped");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && p_ready |=> busy_q)
		else $error("number not loaded");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q < 5'd20)
		else $error("digit count out of range");
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives 64-bit values into the decimal digit converter and checks each
// digit word against a division-by-ten predictor, under random stalls.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [b2d_pkg::CHAR_W-1:0] digit_char;
		logic                       last_digit;
	} digit_word_t;

	typedef struct {
		logic [63:0] value;
		int          ndig;   // typed-in digit count, 0 = predictor only
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	b2d_in_if  inp();
	b2d_out_if outp();

	binary_to_decimal_digits u_dut (.clk(clk), .arst_n(arst_n), .inp(inp), .outp(outp));

	digit_word_t pending_digits[$];
	int          errors = 0;
	int          cycles = 0;
	bit          long_stall = 1'b0;
	bit          drained = 1'b0;

	stim_row_t rows[] = '{
		'{64'd0, 1}, '{64'd9, 1}, '{64'd10, 2}, '{64'd99, 2}, '{64'd100, 3},
		'{64'hFFFF_FFFF_FFFF_FFFF, 20}, '{64'h8000_0000_0000_0000, 19},
		'{64'd10000000000000000000, 20}, '{64'd9999999999999999999, 19},
		'{64'd1, 1}, '{64'hFFFF_FFFF, 10}, '{64'd1234567890, 10},
		'{64'h5555_5555_5555_5555, 0}, '{64'hAAAA_AAAA_AAAA_AAAA, 0},
		'{64'd1000000000000000000, 19}
	};

	// Expected digit words of one value, most significant digit first
	function automatic void predict_digits(input logic [63:0] v);
		logic [3:0] rev[$];
		logic [63:0] x;
		digit_word_t w;
		x = v;
		do begin
			rev.push_back(4'(x % 64'd10));
			x = x / 64'd10;
		end while (x != 0 && rev.size() < b2d_pkg::MAX_DIGITS);
		for (int k = rev.size() - 1; k >= 0; k--) begin
			w.digit_char = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(rev[k]);
			w.last_digit = (k == 0);
			pending_digits.push_back(w);
		end
	endfunction

	task automatic send_value(input logic [63:0] v, input int ndig);
		int gap;
		int before_n;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			inp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		inp.valid <= 1'b1;
		inp.value <= v;
		@(posedge clk);
		while (!inp.ready)
			@(posedge clk);
		before_n = pending_digits.size();
		predict_digits(v);
		if (ndig != 0 && pending_digits.size() - before_n != ndig) begin
			$display("%0t: digit count for %0d expected %0d actual %0d", $time, v,
				ndig, pending_digits.size() - before_n);
			errors++;
		end
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int nb;
		v = {$urandom, $urandom};
		nb = $urandom_range(1, 64);
		if ($urandom_range(0, 2) != 0)
			v = v >> (64 - nb);
		if ($urandom_range(0, 15) == 0)
			v = 0;
		return v;
	endfunction

	// sink side: random stalls, plus one long hold-off
	initial begin
		int gap;
		outp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_stall) begin
				outp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_stall = 1'b0;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				outp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			outp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		digit_word_t exp_w;
		if (arst_n && outp.valid && outp.ready) begin
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected word expected none actual %0d/%0b", $time,
					outp.digit_char, outp.last_digit);
				errors++;
			end else begin
				exp_w = pending_digits.pop_front();
				if (outp.digit_char !== exp_w.digit_char
						|| outp.last_digit !== exp_w.last_digit) begin
					$display("%0t: word mismatch expected %0d/%0b actual %0d/%0b", $time,
						exp_w.digit_char, exp_w.last_digit, outp.digit_char, outp.last_digit);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		inp.valid = 1'b0;
		inp.value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_value(rows[i].value, rows[i].ndig);
		inp.valid <= 1'b0;
		// pause until all digits are out
		while (pending_digits.size() != 0)
			@(posedge clk);
		long_stall = 1'b1;
		for (int i = 0; i < 300; i++)
			send_value(random_value(), 0);
		inp.valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_digits.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
